>>> rtl/kdc_pkg.sv
`timescale 1ns / 1ps
// Package for the k-mer distinct counter: shared constants, the controller state type,
// the command and status bundles between controller and datapath, and decode helpers.
// Depends on nothing; every other file of the block imports it.
package kdc_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int unsigned TableDepthDef = 65536;
  localparam int unsigned LenBitsDef    = 32;

  // Fixed field and state widths.
  localparam int unsigned CharW   = 8;
  localparam int unsigned KlenW   = 5;
  localparam int unsigned KeyW    = 62;
  localparam int unsigned DistW   = 17;
  localparam int unsigned PosW    = 32;
  localparam int unsigned EpochW  = 8;
  localparam int unsigned HashW   = 64;
  localparam int unsigned HalfW   = 32;

  // Configuration port layout.
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam logic        RegKmerLen = 1'b0;

  // Register reset value and run saturation point.
  localparam logic [KlenW-1:0] KmerLenRst = 5'd21;
  localparam logic [KlenW-1:0] KmerMax    = 5'd31;

  // Multiplicative hash constant, split into 32-bit halves.
  localparam logic [HashW-1:0] HashMul   = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [HalfW-1:0] HashMulHi = HashMul[63:32];
  localparam logic [HalfW-1:0] HashMulLo = HashMul[31:0];
  localparam int unsigned      HashShift = 29;

  // Character codes and their two-bit base codes.
  localparam logic [CharW-1:0] CharUpA = 8'h41;
  localparam logic [CharW-1:0] CharUpC = 8'h43;
  localparam logic [CharW-1:0] CharUpG = 8'h47;
  localparam logic [CharW-1:0] CharUpT = 8'h54;
  localparam logic [CharW-1:0] CharLoA = 8'h61;
  localparam logic [CharW-1:0] CharLoC = 8'h63;
  localparam logic [CharW-1:0] CharLoG = 8'h67;
  localparam logic [CharW-1:0] CharLoT = 8'h74;

  localparam logic [1:0] BaseA = 2'd0;
  localparam logic [1:0] BaseC = 2'd1;
  localparam logic [1:0] BaseG = 2'd2;
  localparam logic [1:0] BaseT = 2'd3;

  // Controller states.
  typedef enum logic [3:0] {
    StSweep,
    StIdle,
    StMul0,
    StMul1,
    StMul2,
    StMix,
    StMod,
    StRead,
    StCheck,
    StFinish
  } kdc_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic mul0;
    logic mul1;
    logic mul2;
    logic mix;
    logic mod_step;
    logic rd_en;
    logic probe_next;
    logic insert;
    logic set_ovf;
    logic emit;
    logic sweep_wr;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ins_req;
    logic last;
    logic mod_done;
    logic slot_empty;
    logic key_match;
    logic probe_end;
    logic out_busy;
    logic sweep_done;
    logic epoch_wrap;
  } sts_t;

  // Decodes a character: bit 2 is set for a base, bits 1:0 hold its code.
  function automatic logic [2:0] base_decode(input logic [CharW-1:0] c);
    logic [2:0] r;
    case (c) inside
      CharUpA, CharLoA: r = {1'b1, BaseA};
      CharUpC, CharLoC: r = {1'b1, BaseC};
      CharUpG, CharLoG: r = {1'b1, BaseG};
      CharUpT, CharLoT: r = {1'b1, BaseT};
      default:          r = '0;
    endcase
    return r;
  endfunction

  // Mask that keeps the low 2k bits of the rolling code.
  function automatic logic [KeyW-1:0] kmer_mask(input logic [KlenW-1:0] k);
    logic [KeyW-1:0] m;
    m = '0;
    for (int i = 0; i < KeyW / 2; i++) begin
      m[2*i +: 2] = (KlenW'(i) < k) ? 2'b11 : 2'b00;
    end
    return m;
  endfunction

endpackage

>>> rtl/kdc_ctrl.sv
`timescale 1ns / 1ps
// Controller of the k-mer distinct counter: sequences accept, hashing, table probes,
// result hand-off and the table clearing pass. Depends on kdc_pkg.
module kdc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  kdc_pkg::sts_t sts_i,
  output kdc_pkg::cmd_t cmd_o
);
  import kdc_pkg::*;

  kdc_state_e state_q, state_d;

  // State register; reset starts with a clearing pass over the table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StSweep;
    end else begin
      state_q <= state_d;
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StSweep:  if (sts_i.sweep_done) state_d = StIdle;
      StIdle:   if (in_valid_i) state_d = StMul0;
      StMul0:   state_d = sts_i.ins_req ? StMul1 : StFinish;
      StMul1:   state_d = StMul2;
      StMul2:   state_d = StMix;
      StMix:    state_d = StMod;
      StMod:    if (sts_i.mod_done) state_d = StRead;
      StRead:   state_d = StCheck;
      StCheck: begin
        if (sts_i.slot_empty || sts_i.key_match || sts_i.probe_end) begin
          state_d = StFinish;
        end else begin
          state_d = StRead;
        end
      end
      StFinish: begin
        if (!sts_i.last) begin
          state_d = StIdle;
        end else if (!sts_i.out_busy) begin
          state_d = sts_i.epoch_wrap ? StSweep : StIdle;
        end
      end
      default:  state_d = StSweep;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      StSweep: cmd_o.sweep_wr = 1'b1;
      StIdle:  cmd_o.accept   = in_valid_i;
      StMul0:  cmd_o.mul0     = 1'b1;
      StMul1:  cmd_o.mul1     = 1'b1;
      StMul2:  cmd_o.mul2     = 1'b1;
      StMix:   cmd_o.mix      = 1'b1;
      StMod:   cmd_o.mod_step = 1'b1;
      StRead:  cmd_o.rd_en    = 1'b1;
      StCheck: begin
        if (sts_i.slot_empty) begin
          cmd_o.insert = 1'b1;
        end else if (!sts_i.key_match) begin
          cmd_o.set_ovf    = sts_i.probe_end;
          cmd_o.probe_next = !sts_i.probe_end;
        end
      end
      StFinish: cmd_o.emit = sts_i.last && !sts_i.out_busy;
      default: cmd_o = '0;
    endcase
  end

  assign in_ready_o = (state_q == StIdle);

endmodule

>>> rtl/kdc_dp.sv
`timescale 1ns / 1ps
// Datapath of the k-mer distinct counter: rolling code, counters, the hash unit with a
// shared 32x32 multiplier, the hash table memory and the result register. Uses kdc_pkg.
module kdc_dp #(
  parameter int unsigned TABLE_DEPTH = kdc_pkg::TableDepthDef,
  parameter int unsigned LEN_BITS    = kdc_pkg::LenBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [kdc_pkg::KlenW-1:0]         kmer_len_i,
  input  logic [kdc_pkg::CharW-1:0]         base_char_i,
  input  logic                              last_char_i,
  input  logic                              out_ready_i,
  input  kdc_pkg::cmd_t                     cmd_i,
  output kdc_pkg::sts_t                     sts_o,
  output logic                              out_valid_o,
  output logic [kdc_pkg::DistW-1:0]         distinct_count_o,
  output logic [kdc_pkg::PosW-1:0]          position_count_o,
  output logic                              table_overflow_o
);
  import kdc_pkg::*;

  localparam int unsigned AW     = $clog2(TABLE_DEPTH);
  localparam int unsigned TW     = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned MW     = EpochW + KeyW;
  localparam bit          IsPow2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
  localparam int unsigned TLW    = (TW > DistW) ? TW : DistW;
  localparam int unsigned LW     = (LEN_BITS > PosW) ? LEN_BITS : PosW;
  localparam logic [AW-1:0] LastSlot = AW'(TABLE_DEPTH - 1);

  // Per-sequence state.
  logic [KeyW-1:0]     code_q, code_d;
  logic [KlenW-1:0]    run_q, run_d;
  logic [LEN_BITS-1:0] seq_q, seq_d;
  logic [TW-1:0]       tally_q;
  logic                ovf_q;
  logic                ins_q, ins_d;
  logic                last_q;
  logic [KlenW-1:0]    k_q;
  logic [EpochW-1:0]   epoch_q;

  // Hash and probe state.
  logic [HashW-1:0]    mul_q, lo_q, hx_q;
  logic [HalfW-1:0]    hi_q;
  logic [AW-1:0]       slot_q, probe_q, sweep_q;
  logic [MW-1:0]       rd_q;
  logic [MW-1:0]       tbl_mem_q [TABLE_DEPTH];

  // Result register.
  logic                out_valid_q;
  logic [DistW-1:0]    dist_q;
  logic [PosW-1:0]     pos_q;
  logic                out_ovf_q;

  logic [2:0]          dec;
  logic [HalfW-1:0]    mul_a, mul_b;
  logic [HashW-1:0]    mul_p, mix_h;
  logic [AW-1:0]       slot_mod, slot_inc;
  logic [HashW-1:0]    hx_next;
  logic                mod_done;
  logic                sweep_done;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [MW-1:0]       mem_wdata;
  logic [LEN_BITS-1:0] k_ext, pos_l;
  logic [LW-1:0]       pos_w;
  logic [TLW-1:0]      tally_w;
  logic [PosW-1:0]     pos_out;
  logic [DistW-1:0]    dist_out;

  // Next rolling code, run length and sequence length for an accepted beat.
  always_comb begin
    dec    = base_decode(base_char_i);
    seq_d  = (&seq_q) ? seq_q : seq_q + LEN_BITS'(1);
    if (dec[2]) begin
      code_d = {code_q[KeyW-3:0], dec[1:0]} & kmer_mask(kmer_len_i);
      run_d  = (run_q == KmerMax) ? run_q : run_q + KlenW'(1);
    end else begin
      code_d = '0;
      run_d  = '0;
    end
    ins_d = dec[2] && (kmer_len_i != '0) && (run_d >= kmer_len_i);
  end

  // Per-sequence state: updated on accept, cleared when the result is handed over.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q  <= '0;
      run_q   <= '0;
      seq_q   <= '0;
      tally_q <= '0;
      ovf_q   <= 1'b0;
      ins_q   <= 1'b0;
      last_q  <= 1'b0;
      epoch_q <= EpochW'(1);
    end else if (cmd_i.accept) begin
      code_q <= code_d;
      run_q  <= run_d;
      seq_q  <= seq_d;
      ins_q  <= ins_d;
      last_q <= last_char_i;
    end else if (cmd_i.emit) begin
      code_q  <= '0;
      run_q   <= '0;
      seq_q   <= '0;
      tally_q <= '0;
      ovf_q   <= 1'b0;
      ins_q   <= 1'b0;
      last_q  <= 1'b0;
      // Stale entries stay empty until the epoch wraps; the sweep then rewrites them.
      epoch_q <= (&epoch_q) ? EpochW'(1) : epoch_q + EpochW'(1);
    end else if (cmd_i.insert) begin
      tally_q <= tally_q + TW'(1);
    end else if (cmd_i.set_ovf) begin
      ovf_q <= 1'b1;
    end
  end

  // The k-mer length in force for this beat.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      k_q <= kmer_len_i;
    end
  end

  // Shared multiplier: low x low, low x high, high x low of key and hash constant.
  always_comb begin
    mul_a = code_q[HalfW-1:0];
    mul_b = HashMulLo;
    if (cmd_i.mul1) begin
      mul_b = HashMulHi;
    end else if (cmd_i.mul2) begin
      mul_a = HalfW'(code_q[KeyW-1:HalfW]);
    end
  end
  assign mul_p = HashW'(mul_a) * HashW'(mul_b);
  assign mix_h = {hi_q + mul_q[HalfW-1:0], lo_q[HalfW-1:0]};

  // Reduction of the mixed hash to a slot index.
  generate
    if (IsPow2) begin : g_mask
      assign slot_mod = hx_q[AW-1:0];
      assign hx_next  = hx_q;
      assign mod_done = 1'b1;
    end else begin : g_rem
      localparam int unsigned DigW   = 8;
      localparam int unsigned YW     = AW + DigW;
      localparam logic [YW-1:0] DepthY = YW'(TABLE_DEPTH);
      localparam logic [HalfW-1:0] Recip = HalfW'(64'h1_0000_0000 / 64'(TABLE_DEPTH));
      logic [3:0]       mcnt_q;
      logic [DigW-1:0]  qe_q;
      logic [YW-1:0]    rem_y, rem_qd, rem_a, rem_b;
      logic [HashW-1:0] rcp_p;

      // Each byte of the hash is reduced in turn: a first step estimates the quotient digit from
      // the reciprocal of the depth and a second subtracts its multiple. The estimate is at most
      // one short, so a single compare and subtract completes the remainder.
      always_comb begin
        rem_y  = {slot_q, hx_q[HashW-1 -: DigW]};
        rcp_p  = HashW'(HalfW'(rem_y)) * HashW'(Recip);
        rem_qd = YW'(qe_q) * DepthY;
        rem_a  = rem_y - rem_qd;
        rem_b  = (rem_a >= DepthY) ? rem_a - DepthY : rem_a;
      end
      assign slot_mod = mcnt_q[0] ? rem_b[AW-1:0] : slot_q;
      assign hx_next  = mcnt_q[0] ? {hx_q[HashW-DigW-1:0], DigW'(0)} : hx_q;
      assign mod_done = (mcnt_q == 4'd15);

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          mcnt_q <= '0;
        end else if (cmd_i.mix) begin
          mcnt_q <= '0;
        end else if (cmd_i.mod_step) begin
          mcnt_q <= mcnt_q + 4'd1;
        end
      end

      // Quotient digit estimate.
      always_ff @(posedge clk_i) begin
        if (cmd_i.mod_step && !mcnt_q[0]) begin
          qe_q <= rcp_p[HalfW +: DigW];
        end
      end
    end
  endgenerate

  assign slot_inc = (slot_q == LastSlot) ? '0 : slot_q + AW'(1);

  // Hash pipeline registers and the probe pointer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul0 || cmd_i.mul1 || cmd_i.mul2) begin
      mul_q <= mul_p;
    end
    if (cmd_i.mul1) begin
      lo_q <= mul_q;
    end
    if (cmd_i.mul2) begin
      hi_q <= lo_q[HashW-1:HalfW] + mul_q[HalfW-1:0];
    end
    if (cmd_i.mix) begin
      hx_q    <= mix_h ^ (mix_h >> HashShift);
      slot_q  <= '0;
      probe_q <= '0;
    end else if (cmd_i.mod_step) begin
      hx_q   <= hx_next;
      slot_q <= slot_mod;
    end else if (cmd_i.probe_next) begin
      slot_q  <= slot_inc;
      probe_q <= probe_q + AW'(1);
    end
  end

  // Clearing pass pointer.
  assign sweep_done = (sweep_q == LastSlot);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep_wr) begin
      sweep_q <= sweep_done ? '0 : sweep_q + AW'(1);
    end
  end

  // Hash table: each entry holds the epoch of its sequence and the key.
  assign mem_we    = cmd_i.sweep_wr || cmd_i.insert;
  assign mem_waddr = cmd_i.sweep_wr ? sweep_q : slot_q;
  assign mem_wdata = cmd_i.sweep_wr ? '0 : {epoch_q, code_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tbl_mem_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.rd_en) begin
      rd_q <= tbl_mem_q[slot_q];
    end
  end

  // Result fields, clamped to their port widths.
  always_comb begin
    k_ext = LEN_BITS'(k_q);
    if ((k_q == '0) || (seq_q < k_ext)) begin
      pos_l = '0;
    end else if (&seq_q) begin
      pos_l = seq_q;
    end else begin
      pos_l = seq_q - k_ext + LEN_BITS'(1);
    end
    pos_w    = LW'(pos_l);
    pos_out  = (pos_w > LW'(32'hFFFF_FFFF)) ? '1 : pos_w[PosW-1:0];
    tally_w  = TLW'(tally_q);
    dist_out = (tally_w > TLW'(17'h1_FFFF)) ? '1 : tally_w[DistW-1:0];
  end

  // Output register: holds a result beat until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      dist_q    <= dist_out;
      pos_q     <= pos_out;
      out_ovf_q <= ovf_q;
    end
  end

  // Status to the controller.
  always_comb begin
    sts_o.ins_req    = ins_q;
    sts_o.last       = last_q;
    sts_o.mod_done   = mod_done;
    sts_o.slot_empty = (rd_q[MW-1:KeyW] != epoch_q);
    sts_o.key_match  = (rd_q[KeyW-1:0] == code_q);
    sts_o.probe_end  = (probe_q == LastSlot);
    sts_o.out_busy   = out_valid_q && !out_ready_i;
    sts_o.sweep_done = sweep_done;
    sts_o.epoch_wrap = &epoch_q;
  end

  assign out_valid_o      = out_valid_q;
  assign distinct_count_o = dist_q;
  assign position_count_o = pos_q;
  assign table_overflow_o = out_ovf_q;

endmodule

>>> rtl/kmer_distinct_counter_top.sv
`timescale 1ns / 1ps
// Top level of the k-mer distinct counter: configuration register, controller and datapath.
// Depends on kdc_pkg, kdc_ctrl and kdc_dp.

// Takes one sequence character per beat and, on the beat marked last, returns the number
// of distinct k-mers, the number of k-mer positions and an overflow flag. Items are handled
// one at a time. A character that completes no k-mer skips the hashing and the table
// probes; one that completes a k-mer is hashed in three passes through the one 32x32
// multiplier, reduced to a slot index and then settled by read-then-compare probes of the
// linear-probing table on its memory. When TABLE_DEPTH is not a power of two, the slot
// index is reduced a byte at a time by reciprocal multiplication. A last character waits
// until the previous result beat has been taken. After reset, and again after every 255th
// sequence, a clearing pass runs over every slot of the table and no character is taken
// meanwhile; configuration writes are taken at any time.
module kmer_distinct_counter_top #(
  parameter int unsigned TABLE_DEPTH = kdc_pkg::TableDepthDef,
  parameter int unsigned LEN_BITS    = kdc_pkg::LenBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kdc_pkg::CfgAddrW-1:0]  paddr,
  input  logic [kdc_pkg::CfgDataW-1:0]  pwdata,
  output logic [kdc_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready,
  // Character input.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [kdc_pkg::CharW-1:0]     base_char_i,
  input  logic                          last_char_i,
  // Result output.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [kdc_pkg::DistW-1:0]     distinct_count_o,
  output logic [kdc_pkg::PosW-1:0]      position_count_o,
  output logic                          table_overflow_o
);
  import kdc_pkg::*;

  logic [KlenW-1:0] kmer_len_q;
  logic             reg_sel;
  cmd_t             cmd;
  sts_t             sts;

  // Register file: k-mer length in word 0.
  assign reg_sel = (paddr[2] == RegKmerLen);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_len_q <= KmerLenRst;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      kmer_len_q <= pwdata[KlenW-1:0];
    end
  end

  assign prdata = reg_sel ? CfgDataW'(kmer_len_q) : '0;

  kdc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kdc_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .LEN_BITS    (LEN_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .kmer_len_i       (kmer_len_q),
    .base_char_i      (base_char_i),
    .last_char_i      (last_char_i),
    .out_ready_i      (out_ready_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .distinct_count_o (distinct_count_o),
    .position_count_o (position_count_o),
    .table_overflow_o (table_overflow_o)
  );

endmodule

>>> rtl/kdc_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the k-mer distinct counter, bound to the top level.
// Depends on kdc_pkg for port widths and the default table depth.
module kdc_checker #(
  parameter int unsigned TABLE_DEPTH = kdc_pkg::TableDepthDef
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [kdc_pkg::CfgAddrW-1:0]  paddr,
  input logic [kdc_pkg::CfgDataW-1:0]  pwdata,
  input logic [kdc_pkg::CfgDataW-1:0]  prdata,
  input logic                          pready,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [kdc_pkg::CharW-1:0]     base_char_i,
  input logic                          last_char_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [kdc_pkg::DistW-1:0]     distinct_count_o,
  input logic [kdc_pkg::PosW-1:0]      position_count_o,
  input logic                          table_overflow_o
);
  import kdc_pkg::*;

  // Count reported when every slot of the table is taken.
  localparam logic [DistW-1:0] DistFull =
    (TABLE_DEPTH > 131071) ? 17'h1_FFFF : DistW'(TABLE_DEPTH);

  // An offered character beat holds until it is taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(base_char_i) && $stable(last_char_i))
    else $error("input beat changed before it was taken");

  // A result beat holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(distinct_count_o)
      && $stable(position_count_o) && $stable(table_overflow_o))
    else $error("result beat changed before it was taken");

  // Characters are processed one at a time: no accept on the cycle after an accept.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("character taken while the previous one is still in work");

  // A dropped k-mer means every slot was already taken.
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && table_overflow_o |-> distinct_count_o == DistFull)
    else $error("overflow reported with free slots left");

  // The k-mer length reads back as written.
  a_cfg_rb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && (paddr[2] == RegKmerLen)
      |=> (paddr[2] != RegKmerLen) || (prdata[KlenW-1:0] == $past(pwdata[KlenW-1:0])))
    else $error("k-mer length register does not read back");

endmodule

bind kmer_distinct_counter_top kdc_checker #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_kdc_checker (.*);
